// ----- hw/rtl/hpe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hpe_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SMALL = 2'd1,
    ST_FEW   = 2'd2
  } status_t;

  // Fixed field widths.
  localparam int PERIOD_W = 18;
  localparam int SPAN_W   = 11;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_MIN_THIRD_SPAN = 1'b0;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 11'd10;

  // Division by three as a multiply by ceil(2^17 / 3) and a shift.
  // Exact for every value below 2^17.
  localparam int RECIP3_SHIFT = 17;
  localparam logic [RECIP3_SHIFT-1:0] RECIP3 = 17'd43691;

  // Period scale: thousandths of a sample.
  localparam int MILLI = 1000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    set_thr;
    logic    scan_init;
    logic    scan;
    logic    div_start;
    logic    res_write;
    logic    clear;
    status_t res_status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic third_low;
    logic scan_done;
    logic few;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hpe_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpe_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hpe_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpe_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  always_comb begin
    rem_sh  = {rem_r, q_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
    rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  // Control of the iteration; done pulses for one cycle after the final step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// ----- hw/rtl/hpe_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpe_dp #(
  parameter int MAX_SAMPLES   = 256,
  parameter int MAX_CROSSINGS = 15,
  parameter int SAMPLE_BITS   = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire hpe_pkg::ctrl_cmd_t                  cmd,
  output hpe_pkg::dp_stat_t                        stat,
  input  wire logic [SAMPLE_BITS-1:0]              in_sample,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [hpe_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [hpe_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic      [hpe_pkg::CFG_DATA_W-1:0]      prdata,
  output logic      [hpe_pkg::PERIOD_W-1:0]        out_period_milli,
  output logic      [1:0]                          out_status
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int LW = $clog2(MAX_SAMPLES + 1);
  localparam int KW = $clog2(MAX_CROSSINGS + 1);
  localparam int CW = (SB > hpe_pkg::SPAN_W) ? SB : hpe_pkg::SPAN_W;
  localparam int PW = SB + hpe_pkg::RECIP3_SHIFT;
  localparam int NW = AW + 10;
  localparam int QW = (NW > hpe_pkg::PERIOD_W) ? NW : hpe_pkg::PERIOD_W;

  logic [LW-1:0]                 len_r;
  logic [SB-1:0]                 min_r;
  logic [SB-1:0]                 max_r;
  logic [hpe_pkg::SPAN_W-1:0]    span_r;
  logic [PW-1:0]                 prod_r;
  logic [SB-1:0]                 low_r;
  logic [SB-1:0]                 high_r;
  logic [LW-1:0]                 rd_addr_r;
  logic                          rd_pend_r;
  logic [AW-1:0]                 rd_idx_r;
  logic [SB-1:0]                 prev_r;
  logic                          have_prev_r;
  logic                          armed_r;
  logic [KW-1:0]                 cnt_r;
  logic [AW-1:0]                 first_r;
  logic [AW-1:0]                 last_r;
  logic [hpe_pkg::PERIOD_W-1:0]  period_r;
  hpe_pkg::status_t              status_r;

  logic                          wr_en;
  logic [SB-1:0]                 diff;
  logic [SB-1:0]                 third;
  logic                          room;
  logic                          issue;
  logic [SB-1:0]                 rdata;
  logic [AW-1:0]                 pos;
  logic                          armed_nxt;
  logic [KW-1:0]                 cnt_nxt;
  logic [AW-1:0]                 first_nxt;
  logic [AW-1:0]                 last_nxt;
  logic [AW-1:0]                 spacing;
  logic [NW-1:0]                 div_num;
  logic [KW-1:0]                 div_den;
  logic                          div_done;
  logic [NW-1:0]                 quot;
  logic [QW-1:0]                 quot_ext;
  logic                          cfg_wr;

  // Configuration register access.
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[hpe_pkg::CFG_ADDR_W-1:2] == hpe_pkg::REG_MIN_THIRD_SPAN);
  assign prdata = (paddr[hpe_pkg::CFG_ADDR_W-1:2] == hpe_pkg::REG_MIN_THIRD_SPAN)
                  ? hpe_pkg::CFG_DATA_W'(span_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= hpe_pkg::SPAN_RESET;
    end else if (cfg_wr) begin
      span_r <= pwdata[hpe_pkg::SPAN_W-1:0];
    end
  end

  // Sample store; samples past capacity are dropped.
  assign wr_en = cmd.load && (len_r < LW'(MAX_SAMPLES));

  hpe_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (len_r[AW-1:0]),
    .wdata (in_sample),
    .raddr (rd_addr_r[AW-1:0]),
    .rdata (rdata)
  );

  // Third of the swing: multiply by the reciprocal, then shift.
  assign diff  = (max_r >= min_r) ? (max_r - min_r) : '0;
  assign third = prod_r[PW-1:hpe_pkg::RECIP3_SHIFT];

  always_ff @(posedge clk) begin
    prod_r <= PW'(diff) * PW'(hpe_pkg::RECIP3);
  end

  // Thresholds.
  always_ff @(posedge clk) begin
    if (cmd.set_thr) begin
      low_r  <= min_r + third;
      high_r <= max_r - third;
    end
  end

  // Scan reads one sample a cycle; each new sample pairs with the one before.
  assign room  = (rd_addr_r < len_r) && (cnt_r < KW'(MAX_CROSSINGS));
  assign issue = cmd.scan && room;
  assign pos   = rd_idx_r - AW'(2);

  // Detector update for the pair now at hand.
  always_comb begin
    armed_nxt = armed_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    if (rd_pend_r && have_prev_r && (cnt_r < KW'(MAX_CROSSINGS))) begin
      if (!armed_r) begin
        if ((prev_r > low_r) && (rdata <= low_r)) begin
          armed_nxt = 1'b1;
        end
      end else if ((prev_r <= high_r) && (rdata > high_r)) begin
        if (cnt_r == '0) begin
          first_nxt = pos;
        end
        last_nxt  = pos;
        cnt_nxt   = cnt_r + 1'b1;
        armed_nxt = 1'b0;
      end
    end
  end

  // Frame state: cleared after each result, updated while loading and scanning.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      len_r   <= '0;
      min_r   <= {SB{1'b1}};
      max_r   <= '0;
      armed_r <= 1'b0;
      cnt_r   <= '0;
      first_r <= '0;
      last_r  <= '0;
    end else begin
      if (wr_en) begin
        len_r <= len_r + 1'b1;
        if (in_sample > max_r) begin
          max_r <= in_sample;
        end
        if (in_sample < min_r) begin
          min_r <= in_sample;
        end
      end
      armed_r <= armed_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

  // Read sequencing for the scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r   <= '0;
      rd_pend_r   <= 1'b0;
      have_prev_r <= 1'b0;
    end else if (cmd.scan_init) begin
      rd_addr_r   <= LW'(2);
      rd_pend_r   <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      rd_pend_r <= issue;
      if (issue) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (rd_pend_r) begin
        have_prev_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr_r[AW-1:0];
    if (rd_pend_r) begin
      prev_r <= rdata;
    end
  end

  // Rounded mean spacing of the captures.
  assign spacing = last_r - first_r;
  assign div_den = cnt_r - 1'b1;
  assign div_num = (NW'(spacing) * NW'(hpe_pkg::MILLI)) + NW'(div_den >> 1);

  hpe_div #(
    .NUM_W (NW),
    .DEN_W (KW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  assign quot_ext = QW'(quot);

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_write) begin
      status_r <= cmd.res_status;
      period_r <= (cmd.res_status == hpe_pkg::ST_OK) ?
                  quot_ext[hpe_pkg::PERIOD_W-1:0] : '0;
    end
  end

  assign out_period_milli = period_r;
  assign out_status       = status_r;

  // Status to the controller.
  always_comb begin
    stat.third_low = CW'(third) < CW'(span_r);
    stat.scan_done = !room && !rd_pend_r;
    stat.few       = cnt_r < KW'(2);
    stat.div_done  = div_done;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hpe_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire hpe_pkg::dp_stat_t  stat,
  output hpe_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_THIRD,
    S_CHECK,
    S_SCAN,
    S_DIV_START,
    S_DIV_WAIT,
    S_RESULT
  } state_t;

  state_t           state_r;
  logic             out_valid_r;
  hpe_pkg::status_t status_sel_r;
  logic             slot_free;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // Commands decoded from the state.
  always_comb begin
    cmd            = '0;
    cmd.res_status = status_sel_r;
    case (state_r)
      S_LOAD: begin
        cmd.load = in_valid;
      end
      S_CHECK: begin
        cmd.set_thr   = !stat.third_low;
        cmd.scan_init = !stat.third_low;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
      end
      S_RESULT: begin
        cmd.res_write = slot_free;
        cmd.clear     = slot_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      out_valid_r  <= 1'b0;
      status_sel_r <= hpe_pkg::ST_OK;
    end else begin
      // A new result replaces the one taken at this edge; otherwise a taken result leaves.
      if ((state_r == S_RESULT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_valid && in_last) begin
            state_r <= S_THIRD;
          end
        end
        S_THIRD: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (stat.third_low) begin
            status_sel_r <= hpe_pkg::ST_SMALL;
            state_r      <= S_RESULT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.scan_done) begin
            if (stat.few) begin
              status_sel_r <= hpe_pkg::ST_FEW;
              state_r      <= S_RESULT;
            end else begin
              state_r <= S_DIV_START;
            end
          end
        end
        S_DIV_START: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            status_sel_r <= hpe_pkg::ST_OK;
            state_r      <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            state_r <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hysteresis_period_estimator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_ready   in_sample, in_last
// out_      output     out_valid/out_ready out_period_milli, out_status
// config    APB        psel/penable/pready paddr, pwdata, prdata (min_third_span at 0x0)
//
// A frame of N stored samples loads at one item per cycle; later samples are dropped.
// After the last item in_ready stays low through the swing check, the scan (one store read
// per position), the division and the loading of the result, which waits until the output
// register is free. Early exits end sooner.
// Reset (rst_n, synchronous) clears the frame state and sets min_third_span to 10.
// A result waits in the output register while the next frame loads behind it.

module hysteresis_period_estimator #(
  parameter int MAX_SAMPLES   = 256,
  parameter int MAX_CROSSINGS = 15,
  parameter int SAMPLE_BITS   = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [SAMPLE_BITS-1:0]             in_sample,
  input  wire logic                               in_last,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [hpe_pkg::PERIOD_W-1:0]       out_period_milli,
  output logic      [1:0]                         out_status,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [hpe_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [hpe_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [hpe_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                    pready
);

  hpe_pkg::ctrl_cmd_t cmd;
  hpe_pkg::dp_stat_t  stat;

  // Register accesses always complete in the access cycle.
  assign pready = 1'b1;

  hpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hpe_dp #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .MAX_CROSSINGS (MAX_CROSSINGS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_sample        (in_sample),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .out_period_milli (out_period_milli),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

// ----- dv/hysteresis_period_estimator_test.sv -----
`timescale 1ns / 1ps

module hysteresis_period_estimator_test;

  localparam int MAX_SAMPLES   = 256;
  localparam int MAX_CROSSINGS = 15;
  localparam int SAMPLE_BITS   = 12;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;

  localparam int RESET_CYCLES  = 3;
  localparam int HOLD_CYCLES   = 1500;
  localparam int SETTLE_CYCLES = 320;
  localparam int TIMEOUT_NS    = 5_000_000;

  localparam logic [hpe_pkg::SPAN_W-1:0]     SPAN_TOP  = 11'd1365;
  localparam logic [hpe_pkg::CFG_ADDR_W-1:0] SPAN_ADDR = {hpe_pkg::REG_MIN_THIRD_SPAN, 2'b00};

  typedef enum int unsigned {W_SQUARE, W_TRIANGLE, W_SAW, W_NOISE} wave_t;
  typedef enum int unsigned {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PULSE} ready_mode_t;

  typedef struct {
    logic [hpe_pkg::PERIOD_W-1:0] period;
    hpe_pkg::status_t             status;
  } estimate_t;

  // Clock, reset and block inputs, all known from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [hpe_pkg::PERIOD_W-1:0] out_period_milli;
  logic [1:0] out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [hpe_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [hpe_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [hpe_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  // Predictor state: the frame as the block should hold it.
  logic [SAMPLE_BITS-1:0] held_samples [MAX_SAMPLES];
  int unsigned held_count = 0;
  logic [SAMPLE_BITS-1:0] held_low = '1;
  logic [SAMPLE_BITS-1:0] held_high = '0;
  logic [hpe_pkg::SPAN_W-1:0] span_setting = hpe_pkg::SPAN_RESET;
  estimate_t pending_estimates[$];

  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  // Receiver stall pattern and the long hold-off.
  ready_mode_t ready_mode = RDY_ALWAYS;
  logic [7:0] ready_left = '0;
  logic hold_start = 1'b0;
  int unsigned hold_left = 0;

  hysteresis_period_estimator #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_CROSSINGS(MAX_CROSSINGS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_period_milli(out_period_milli),
    .out_status      (out_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result of the frame held so far.
  function automatic estimate_t estimate_period();
    estimate_t   res;
    int unsigned top, bottom, third, lo_thr, hi_thr;
    int unsigned hits, first_hit, last_hit, i;
    logic        primed;
    res.period = '0;
    res.status = hpe_pkg::ST_OK;
    top = held_high;
    bottom = held_low;
    third = (top >= bottom) ? (top - bottom) / 3 : 0;
    if (third < span_setting) begin
      res.status = hpe_pkg::ST_SMALL;
      return res;
    end
    lo_thr = bottom + third;
    hi_thr = top - third;
    hits = 0;
    first_hit = 0;
    last_hit = 0;
    primed = 1'b0;
    for (i = 1; i + 2 < held_count && hits < MAX_CROSSINGS; i++) begin
      if (!primed) begin
        if (held_samples[i+1] > lo_thr && held_samples[i+2] <= lo_thr) primed = 1'b1;
      end else if (held_samples[i+1] <= hi_thr && held_samples[i+2] > hi_thr) begin
        if (hits == 0) first_hit = i;
        last_hit = i;
        hits++;
        primed = 1'b0;
      end
    end
    if (hits < 2) res.status = hpe_pkg::ST_FEW;
    else res.period = hpe_pkg::PERIOD_W'((hpe_pkg::MILLI * (last_hit - first_hit)
                                          + (hits - 1) / 2) / (hits - 1));
    return res;
  endfunction

  // Track every accepted item and queue a result at the end of each frame.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (held_count < MAX_SAMPLES) begin
        held_samples[held_count] = in_sample;
        held_count++;
        if (in_sample > held_high) held_high = in_sample;
        if (in_sample < held_low) held_low = in_sample;
      end
      if (in_last) begin
        pending_estimates.push_back(estimate_period());
        held_count = 0;
        held_low = '1;
        held_high = '0;
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Compare each accepted result with the oldest expected estimate.
  always @(posedge clk) begin
    estimate_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch($sformatf("unexpected result period %0d status %0d",
                                  out_period_milli, out_status));
      end else begin
        want = pending_estimates.pop_front();
        if (out_period_milli !== want.period)
          report_mismatch($sformatf("period_milli %0d, expected %0d",
                                    out_period_milli, want.period));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
      end
    end
  end

  // Long receiver hold-off, counted here once the test requests it.
  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Receiver ready pattern: a new stall mode every so often.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_left <= '0;
    end else begin
      if (ready_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        ready_left <= 8'($urandom_range(16, 128));
      end else begin
        ready_left <= ready_left - 1'b1;
      end
      if (hold_left != 0) out_ready <= 1'b0;
      else begin
        case (ready_mode)
          RDY_ALWAYS: out_ready <= 1'b1;
          RDY_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
          RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= ready_left[2];
        endcase
      end
    end
  end

  // Offer one item in bursts with random gaps; return at the edge that takes it.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_sample <= value;
    in_last <= is_last;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // Stop sending and wait until every expected result has come out.
  task automatic settle_all_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_span(input logic [hpe_pkg::SPAN_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SPAN_ADDR;
    pwdata <= {{(hpe_pkg::CFG_DATA_W - hpe_pkg::SPAN_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    span_setting = value;
  endtask

  // Frame of lo, hi, lo, hi, ... ending with the last flag.
  task automatic send_alternating(input int unsigned lo, input int unsigned hi,
                                  input int unsigned len);
    int unsigned n;
    for (n = 0; n < len; n++)
      send_sample(SAMPLE_BITS'((n % 2) ? hi : lo), n == len - 1);
  endtask

  // One frame of a periodic waveform with optional additive noise.
  task automatic send_wave(input int unsigned len, input wave_t shape,
                           input int unsigned base, input int unsigned swing,
                           input int unsigned period, input int unsigned noise);
    int unsigned phase, pos, half, level, n;
    phase = $urandom_range(0, period - 1);
    half = period / 2;
    for (n = 0; n < len; n++) begin
      pos = (n + phase) % period;
      case (shape)
        W_SQUARE:   level = (pos < half) ? base + swing : base;
        W_TRIANGLE: level = (pos < half) ? base + swing * pos / half
                                         : base + swing * (period - pos) / (period - half);
        W_SAW:      level = base + swing * pos / (period - 1);
        default:    level = base + $urandom_range(0, swing);
      endcase
      if (noise != 0) level += $urandom_range(0, noise);
      if (level > SAMPLE_MAX) level = SAMPLE_MAX;
      send_sample(level[SAMPLE_BITS-1:0], n == len - 1);
    end
  endtask

  task automatic send_random_wave(input int unsigned len);
    int unsigned base, swing, noise;
    base = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3000);
    swing = $urandom_range(0, SAMPLE_MAX - base);
    noise = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, swing / 8);
    send_wave(len, wave_t'($urandom_range(0, 3)), base, swing, $urandom_range(2, 24), noise);
  endtask

  // Reset value of the register: one-sample frame, too-short frame, two captures.
  task automatic test_short_frames();
    send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b1);
    send_alternating(0, SAMPLE_MAX, 3);
    send_alternating(0, SAMPLE_MAX, 8);
  endtask

  // Zero register with a flat frame, and the largest register at and below its limit.
  task automatic test_span_extremes();
    settle_all_results();
    write_span('0);
    send_alternating(2048, 2048, 4);
    settle_all_results();
    write_span(SPAN_TOP);
    send_alternating(0, SAMPLE_MAX, 8);
    send_alternating(0, SAMPLE_MAX - 1, 4);
  endtask

  // Well-formed waveforms of random shape under several register settings.
  task automatic test_periodic_frames();
    logic [hpe_pkg::SPAN_W-1:0] spans [5];
    int unsigned p, sent, len;
    spans[0] = '0;
    spans[1] = hpe_pkg::SPAN_W'($urandom_range(1, 120));
    spans[2] = hpe_pkg::SPAN_W'($urandom_range(120, 900));
    spans[3] = SPAN_TOP;
    spans[4] = hpe_pkg::SPAN_W'($urandom_range(0, 40));
    for (p = 0; p < 5; p++) begin
      settle_all_results();
      write_span(spans[p]);
      sent = 0;
      while (sent < ((spans[p] == SPAN_TOP) ? 60 : 130)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 80);
        if (spans[p] == SPAN_TOP)
          send_wave(len, W_SQUARE, 0, SAMPLE_MAX, $urandom_range(2, 16), 0);
        else
          send_random_wave(len);
        sent += len;
      end
    end
  endtask

  // Fast waveforms long enough that the scan stops at the capture limit.
  task automatic test_capture_limit();
    int unsigned f, base;
    settle_all_results();
    write_span(hpe_pkg::SPAN_W'($urandom_range(0, 300)));
    send_alternating(0, SAMPLE_MAX, 40);
    for (f = 0; f < 4; f++) begin
      base = $urandom_range(0, 500);
      send_wave($urandom_range(40, 90), wave_t'($urandom_range(0, 1)), base,
                $urandom_range(2000, SAMPLE_MAX - base), $urandom_range(2, 5), 0);
    end
  endtask

  // Frames at and beyond the store size; surplus samples must be dropped.
  task automatic test_frame_overflow();
    int unsigned f, base;
    int unsigned lens [3];
    settle_all_results();
    write_span(hpe_pkg::SPAN_W'($urandom_range(0, 80)));
    lens[0] = MAX_SAMPLES;
    lens[1] = MAX_SAMPLES + 1;
    lens[2] = MAX_SAMPLES + 30;
    for (f = 0; f < 3; f++) begin
      base = $urandom_range(0, 1000);
      send_wave(lens[f], wave_t'($urandom_range(0, 2)), base,
                $urandom_range(1500, SAMPLE_MAX - base), $urandom_range(8, 40),
                $urandom_range(0, 50));
    end
  endtask

  // Receiver holds off for a long stretch while frames keep coming.
  task automatic test_output_hold_off();
    int unsigned f;
    settle_all_results();
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (f = 0; f < 6; f++) send_random_wave($urandom_range(5, 14));
  endtask

  // Unstructured frames: full-range noise and narrow noise of random length.
  task automatic test_noise_frames();
    int unsigned f, n, len, center;
    logic narrow;
    settle_all_results();
    write_span(hpe_pkg::SPAN_W'($urandom_range(0, 40)));
    for (f = 0; f < 14; f++) begin
      len = $urandom_range(1, 30);
      narrow = ($urandom_range(0, 2) == 0);
      center = $urandom_range(0, SAMPLE_MAX - 60);
      for (n = 0; n < len; n++)
        send_sample(SAMPLE_BITS'(narrow ? center + $urandom_range(0, 60)
                                        : $urandom_range(0, SAMPLE_MAX)),
                    n == len - 1);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_frames();
    test_span_extremes();
    test_periodic_frames();
    test_capture_limit();
    test_frame_overflow();
    test_output_hold_off();
    test_noise_frames();
    settle_all_results();
    if (mismatches == 0) begin
      $display("hysteresis_period_estimator verification clean");
    end else begin
      $display("hysteresis_period_estimator verification failed");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("hysteresis_period_estimator verification failed");
    $finish;
  end

endmodule
